[rtl/pss_pkg.sv]
// Shared types, constants and the SHA-256 round constant table for the PSS engine.
package pss_pkg;

	localparam int HASH_WORDS   = 4;
	localparam int EM_BYTES_DEF = 64;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [7:0] TRAILER   = 8'hBC;
	localparam logic [7:0] TOP_CLEAR = 8'h7F;
	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [7:0] DB_ONE    = 8'h01;

	localparam logic [255:0] INIT_H = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// bit lengths of the two single-block messages
	localparam logic [31:0] MPRIME_BITS = 32'd320;
	localparam logic [31:0] SEED_BITS   = 32'd288;

	typedef struct packed {
		logic        kind;
		logic [63:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic [63:0] out_word;
		logic        sig_valid;
		logic        last;
	} out_item_t;

	// one word in the queue between front and back
	typedef struct packed {
		logic        kind;
		logic        last;
		logic [63:0] data_word;
	} job_word_t;

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		case (t)
			6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
			6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
			6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

[rtl/pss_front.sv]
// Front end: accepts input words, tags kind and end of request, queues them for the back end.
module pss_front import pss_pkg::*; #(
	parameter int EM_BYTES = EM_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  wr_data,
	output logic      q_valid,
	output job_word_t q_word,
	input  logic      q_pop
);

	localparam int EM_WORDS  = (EM_BYTES + 7) / 8;
	localparam int REQ_DEPTH = HASH_WORDS + EM_WORDS;
	localparam int CW        = $clog2(REQ_DEPTH);
	localparam int PW        = $clog2(QUEUE_DEPTH);

	logic [CW-1:0] word_count_q;
	logic          request_kind_q;
	logic          kind_eff;
	logic          req_last;
	logic          accept;
	logic          do_pop;
	job_word_t     q_mem [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   fill_q;

	// kind of the first word holds for the whole request
	assign kind_eff = (word_count_q == '0) ? wr_data.kind : request_kind_q;
	assign req_last = kind_eff ? (word_count_q == CW'(REQ_DEPTH - 1))
	                           : (word_count_q == CW'(HASH_WORDS - 1));
	assign full     = (fill_q == (PW+1)'(QUEUE_DEPTH));
	assign accept   = push && !full;
	assign q_valid  = (fill_q != '0);
	assign do_pop   = q_pop && q_valid;
	assign q_word   = q_mem[rd_ptr_q];

	// request word counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q   <= '0;
			request_kind_q <= 1'b0;
		end else if (accept) begin
			request_kind_q <= kind_eff;
			word_count_q   <= req_last ? '0 : word_count_q + 1'b1;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem[wr_ptr_q] <= '{kind: kind_eff, last: req_last, data_word: wr_data.data_word};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (accept) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (accept && !do_pop) fill_q <= fill_q + 1'b1;
			else if (!accept && do_pop) fill_q <= fill_q - 1'b1;
		end
	end

endmodule

[rtl/pss_sha_core.sv]
// Iterative SHA-256 core: one round per cycle over one pre-padded 512-bit block.
module pss_sha_core import pss_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [511:0] block,
	output logic         done,
	output logic [255:0] digest
);

	logic        busy_q;
	logic        fin_q;
	logic        done_q;
	logic [5:0]  round_count_q;
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [255:0] digest_q;
	logic [31:0] big_s1, big_s0, ch, maj, t1, t2, w_new, sm1, sm0;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// round logic
	always_comb begin
		big_s1 = rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25);
		ch     = (e_q & f_q) ^ (~e_q & g_q);
		t1     = h_q + big_s1 + ch + round_k(round_count_q) + w_q[0];
		big_s0 = rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22);
		maj    = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
		t2     = big_s0 + maj;
		sm1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		sm0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		w_new  = sm1 + w_q[9] + sm0 + w_q[0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			fin_q         <= 1'b0;
			done_q        <= 1'b0;
			round_count_q <= '0;
		end else begin
			done_q <= !start && !busy_q && fin_q;
			if (start) begin
				busy_q        <= 1'b1;
				round_count_q <= '0;
			end else if (busy_q) begin
				round_count_q <= round_count_q + 1'b1;
				if (round_count_q == 6'd63) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
			end
		end
	end

	// working variables and schedule window
	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 16; i++) w_q[i] <= block[511 - 32*i -: 32];
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= INIT_H;
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
		if (fin_q) begin
			digest_q <= {INIT_H[255:224] + a_q, INIT_H[223:192] + b_q,
			             INIT_H[191:160] + c_q, INIT_H[159:128] + d_q,
			             INIT_H[127:96] + e_q,  INIT_H[95:64] + f_q,
			             INIT_H[63:32] + g_q,   INIT_H[31:0] + h_q};
		end
	end

	assign done   = done_q;
	assign digest = digest_q;

endmodule

[rtl/pss_back.sv]
// Back end: loads a request, runs the hash and mask blocks, emits encoded words or the verdict.
module pss_back import pss_pkg::*; #(
	parameter int EM_BYTES = EM_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  job_word_t q_word,
	output logic      q_pop,
	output logic      empty,
	input  logic      pop,
	output out_item_t rd_data
);

	localparam int EM_WORDS   = (EM_BYTES + 7) / 8;
	localparam int REQ_DEPTH  = HASH_WORDS + EM_WORDS;
	localparam int CW         = $clog2(REQ_DEPTH);
	localparam int DB_BYTES   = EM_BYTES - 33;
	localparam int MASK_BLKS  = (DB_BYTES + 31) / 32;
	localparam int MASK_BYTES = MASK_BLKS * 32;
	localparam int MASK_W     = MASK_BYTES * 8;
	localparam int EMV_BYTES  = EM_WORDS * 8;
	localparam int EW         = $clog2(EM_WORDS);

	typedef enum logic [5:0] {
		S_LOAD   = 6'b000001,
		S_HSTART = 6'b000010,
		S_HWAIT  = 6'b000100,
		S_MSTART = 6'b001000,
		S_MWAIT  = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

	state_t                   state_q;
	logic [CW-1:0]            load_cnt_q;
	logic                     kind_q;
	logic [63:0]              req_q [REQ_DEPTH];
	logic [255:0]             digest_h_q;
	logic [1:0]               mask_counter_q;
	logic [MASK_BYTES*8-1:0]  mask_q;
	logic [EW-1:0]            emit_idx_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic                     sha_start;
	logic [511:0]             sha_block;
	logic                     sha_done;
	logic [255:0]             sha_digest;
	logic [EMV_BYTES*8-1:0]   em_in;
	logic [EMV_BYTES*8-1:0]   em_enc;
	logic [EMV_BYTES-1:0]     bad;
	logic [255:0]             em_h;
	logic [255:0]             seed;
	logic [63:0]              enc_words [EM_WORDS];
	logic                     ok;
	logic                     out_free;

	pss_sha_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sha_start),
		.block  (sha_block),
		.done   (sha_done),
		.digest (sha_digest)
	);

	// received EM as one byte string
	for (genvar w = 0; w < EM_WORDS; w++) begin : g_emin
		assign em_in[EMV_BYTES*8-1-64*w -: 64] = req_q[HASH_WORDS + w];
		assign enc_words[w] = em_enc[EMV_BYTES*8-1-64*w -: 64];
	end

	// H field of the received EM
	for (genvar j = 0; j < 32; j++) begin : g_emh
		assign em_h[255-8*j -: 8] = em_in[EMV_BYTES*8-1-8*(DB_BYTES+j) -: 8];
	end

	// per byte: encoded value and verify mismatch
	for (genvar i = 0; i < EMV_BYTES; i++) begin : g_byte
		logic [7:0] eb;
		assign eb = em_in[EMV_BYTES*8-1-8*i -: 8];
		if (i < DB_BYTES) begin : g_db
			localparam logic [7:0] PAD  = (i == DB_BYTES - 1) ? DB_ONE : 8'h00;
			localparam logic [7:0] KEEP = (i == 0) ? TOP_CLEAR : 8'hFF;
			logic [7:0] mb;
			assign mb = mask_q[MASK_BYTES*8-1-8*i -: 8];
			assign em_enc[EMV_BYTES*8-1-8*i -: 8] = (mb ^ PAD) & KEEP;
			assign bad[i] = (((eb ^ mb) & KEEP) != PAD);
		end else if (i < EM_BYTES - 1) begin : g_h
			logic [7:0] hb;
			assign hb = digest_h_q[255-8*(i-DB_BYTES) -: 8];
			assign em_enc[EMV_BYTES*8-1-8*i -: 8] = hb;
			assign bad[i] = (eb != hb);
		end else if (i == EM_BYTES - 1) begin : g_tr
			assign em_enc[EMV_BYTES*8-1-8*i -: 8] = TRAILER;
			assign bad[i] = (eb != TRAILER);
		end else begin : g_pad
			assign em_enc[EMV_BYTES*8-1-8*i -: 8] = 8'h00;
			assign bad[i] = 1'b0;
		end
	end

	assign ok       = !(|bad) && !em_in[EMV_BYTES*8-1];
	assign seed     = kind_q ? em_h : digest_h_q;
	assign out_free = !out_valid_q || pop;

	// hash block selection: M' for the first pass, seed||counter for mask passes
	always_comb begin
		if (state_q == S_HSTART) begin
			sha_block = {64'h0, req_q[0], req_q[1], req_q[2], req_q[3],
			             PAD_BYTE, 24'h0, 128'h0, MPRIME_BITS};
		end else begin
			sha_block = {seed, 30'h0, mask_counter_q, PAD_BYTE, 24'h0, 160'h0, SEED_BITS};
		end
		sha_start = (state_q == S_HSTART) || (state_q == S_MSTART);
		q_pop     = (state_q == S_LOAD) && q_valid;
	end

	// request buffer, digest and mask registers, output word
	always_ff @(posedge clk) begin
		if (q_pop) req_q[load_cnt_q] <= q_word.data_word;
		if (state_q == S_HWAIT && sha_done) digest_h_q <= sha_digest;
		// mask blocks shift in from the bottom; the first ends on top
		if (state_q == S_MWAIT && sha_done) mask_q <= MASK_W'({mask_q, sha_digest});
		if (state_q == S_OUT && out_free) begin
			if (kind_q) out_q <= '{out_word: 64'h0, sig_valid: ok, last: 1'b1};
			else out_q <= '{out_word: enc_words[emit_idx_q], sig_valid: 1'b0,
			                last: (emit_idx_q == EW'(EM_WORDS - 1))};
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (pop && out_valid_q) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			load_cnt_q     <= '0;
			kind_q         <= 1'b0;
			mask_counter_q <= '0;
			emit_idx_q     <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (q_valid) begin
						kind_q <= q_word.kind;
						if (q_word.last) begin
							load_cnt_q <= '0;
							state_q    <= S_HSTART;
						end else begin
							load_cnt_q <= load_cnt_q + 1'b1;
						end
					end
				end
				S_HSTART: state_q <= S_HWAIT;
				S_HWAIT: begin
					if (sha_done) begin
						mask_counter_q <= '0;
						state_q        <= S_MSTART;
					end
				end
				S_MSTART: state_q <= S_MWAIT;
				S_MWAIT: begin
					if (sha_done) begin
						if (mask_counter_q == 2'(MASK_BLKS - 1)) begin
							mask_counter_q <= '0;
							emit_idx_q     <= '0;
							state_q        <= S_OUT;
						end else begin
							mask_counter_q <= mask_counter_q + 1'b1;
							state_q        <= S_MSTART;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						if (kind_q || emit_idx_q == EW'(EM_WORDS - 1)) begin
							emit_idx_q <= '0;
							state_q    <= S_LOAD;
						end else begin
							emit_idx_q <= emit_idx_q + 1'b1;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign empty   = !out_valid_q;
	assign rd_data = out_q;

endmodule

[rtl/pss_sha256_encode_verify.sv]
// EMSA-PSS (SHA-256, empty salt) encoder and verifier top level.
// After the last word of a request, the buffered words are loaded, then SHA-256 runs on M'
// and on the mask blocks (1 + ceil((EM_BYTES-33)/32) blocks in all), then results are emitted.
// Throughput: one request at a time in the back end; set by the one-round-per-cycle
// SHA-256 core. Encode emits ceil(EM_BYTES/8) words, verify one word.
// Reset: arst_n low clears the queues, counters and sequencer; data stores are not cleared.
module pss_sha256_encode_verify import pss_pkg::*; #(
	parameter int EM_BYTES = EM_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  wr_data,
	output logic      empty,
	input  logic      pop,
	output out_item_t rd_data
);

	logic      q_valid;
	logic      q_pop;
	job_word_t q_word;

	pss_front #(.EM_BYTES(EM_BYTES)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.wr_data (wr_data),
		.q_valid (q_valid),
		.q_word  (q_word),
		.q_pop   (q_pop)
	);

	pss_back #(.EM_BYTES(EM_BYTES)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_word  (q_word),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.rd_data (rd_data)
	);

endmodule
